[src/assert_macros.svh]
// Assertion macros used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle property, disabled while reset is active.
`define ITDA_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("%m: assertion failed");

// Antecedent in one cycle, consequent in the next.
`define ITDA_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

[src/itda_pkg.sv]
// Package with the types and constants of the integer to decimal ASCII converter.
`timescale 1ns / 1ps

package itda_pkg;

  localparam int WIDTH     = 64;
  localparam int VALUE_W   = 64;
  localparam int CHAR_W    = 8;
  localparam int STEP_BITS = 4;
  localparam int PADW      = ((WIDTH + STEP_BITS - 1) / STEP_BITS) * STEP_BITS;
  localparam int NSTEP     = PADW / STEP_BITS;
  localparam int NDIG      = (WIDTH * 77) / 256 + 1;
  localparam int BCDW      = NDIG * 4;
  localparam int IDXW      = $clog2(NDIG);
  localparam int CNTW      = $clog2(NSTEP);
  localparam int QDEPTH    = 2;
  localparam int QPTRW     = $clog2(QDEPTH);
  localparam int QCNTW     = $clog2(QDEPTH + 1);

  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] ASCII_NINE  = 8'h39;

  localparam logic MODE_SIGNED   = 1'b0;
  localparam logic MODE_UNSIGNED = 1'b1;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               mode;
  } in_t;

  typedef struct packed {
    logic [CHAR_W-1:0] character;
    logic              last;
  } out_t;

  typedef struct packed {
    logic [WIDTH-1:0] mag;
    logic             neg;
  } job_t;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_CONV = 4'b0010,
    S_SIZE = 4'b0100,
    S_EMIT = 4'b1000
  } back_state_e;

endpackage

[src/itda_queue.sv]
// Short job queue between the front and the back of the converter.
`timescale 1ns / 1ps

module itda_queue
  import itda_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t push_data_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output job_t pop_data_o
);

  job_t             mem_q [QDEPTH];
  logic [QPTRW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTRW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNTW-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o     = (cnt_q == QCNTW'(QDEPTH));
  assign empty_o    = (cnt_q == '0);
  assign pop_data_o = mem_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QPTRW'(QDEPTH - 1)) ? '0 : wr_ptr_q + QPTRW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPTRW'(QDEPTH - 1)) ? '0 : rd_ptr_q + QPTRW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + QCNTW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - QCNTW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

[src/itda_front.sv]
// Front end: accepts input transactions and turns them into sign and magnitude jobs.
`timescale 1ns / 1ps

module itda_front
  import itda_pkg::*;
(
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic push_o,
  output job_t push_data_o,
  input  logic full_i
);

  logic [WIDTH-1:0] v;
  logic             neg;

  assign v   = in_data_i.value[WIDTH-1:0];
  assign neg = (in_data_i.mode == MODE_SIGNED) && v[WIDTH-1];

  assign in_stall_o       = full_i;
  assign push_o           = in_valid_i && !full_i;
  assign push_data_o.neg  = neg;
  assign push_data_o.mag  = neg ? WIDTH'(~v + WIDTH'(1)) : v;

endmodule

[src/itda_back.sv]
// Back end: shift-and-add-3 conversion to BCD and character output register.
`timescale 1ns / 1ps

module itda_back
  import itda_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic empty_i,
  input  job_t job_i,
  output logic pop_o,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  back_state_e      state_q, state_d;
  logic [PADW-1:0]  bin_q, bin_d;
  logic [BCDW-1:0]  bcd_q, bcd_d;
  logic [CNTW-1:0]  cnt_q, cnt_d;
  logic [IDXW-1:0]  idx_q, idx_d;
  logic             sign_q, sign_d;
  logic             out_valid_q, out_valid_d;
  out_t             out_q, out_d;
  logic             load;
  logic [BCDW-1:0]  bcd_step;
  logic [PADW-1:0]  bin_step;
  logic [IDXW-1:0]  msd;

  assign load        = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign pop_o       = (state_q == S_IDLE) && !empty_i;

  always_comb begin
    bcd_step = bcd_q;
    bin_step = bin_q;
    for (int s = 0; s < STEP_BITS; s++) begin
      for (int d = 0; d < NDIG; d++) begin
        if (bcd_step[d*4 +: 4] >= 4'd5) begin
          bcd_step[d*4 +: 4] = bcd_step[d*4 +: 4] + 4'd3;
        end
      end
      {bcd_step, bin_step} = {bcd_step[BCDW-2:0], bin_step, 1'b0};
    end
  end

  always_comb begin
    msd = '0;
    for (int d = 0; d < NDIG; d++) begin
      if (bcd_q[d*4 +: 4] != 4'd0) begin
        msd = IDXW'(d);
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    bin_d       = bin_q;
    bcd_d       = bcd_q;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    sign_d      = sign_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (load) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      S_IDLE: begin
        if (!empty_i) begin
          bin_d   = PADW'(job_i.mag);
          bcd_d   = '0;
          sign_d  = job_i.neg;
          cnt_d   = '0;
          state_d = S_CONV;
        end
      end
      S_CONV: begin
        bin_d = bin_step;
        bcd_d = bcd_step;
        cnt_d = cnt_q + CNTW'(1);
        if (cnt_q == CNTW'(NSTEP - 1)) begin
          state_d = S_SIZE;
        end
      end
      S_SIZE: begin
        idx_d   = msd;
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (load) begin
          out_valid_d = 1'b1;
          if (sign_q) begin
            out_d.character = ASCII_MINUS;
            out_d.last      = 1'b0;
            sign_d          = 1'b0;
          end else begin
            out_d.character = ASCII_ZERO + CHAR_W'(bcd_q[idx_q*4 +: 4]);
            out_d.last      = (idx_q == '0);
            if (idx_q == '0) begin
              state_d = S_IDLE;
            end else begin
              idx_d = idx_q - IDXW'(1);
            end
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q  <= bin_d;
    bcd_q  <= bcd_d;
    cnt_q  <= cnt_d;
    idx_q  <= idx_d;
    sign_q <= sign_d;
    out_q  <= out_d;
  end

endmodule

[src/integer_to_decimal_ascii.sv]
// Integer to decimal ASCII converter: the top level.
// Each input transaction carries a 64-bit value and a mode bit (0 signed, 1 unsigned); the
// block returns its decimal text most significant digit first, one character per output
// transaction, with a leading minus sign for negative signed values and last set on the final
// digit. The back end converts with a shift-and-add-3 loop that consumes four bits per cycle;
// each number passes through a load step, the conversion steps, a sizing step that finds the
// most significant digit and one emit step per character. A two-entry queue lets the front end
// accept up to two further numbers while one is being converted or emitted.
`timescale 1ns / 1ps

module integer_to_decimal_ascii
  import itda_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  logic push, full, pop, empty;
  job_t push_data, pop_data;

  itda_front u_front (
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .push_o      (push),
    .push_data_o (push_data),
    .full_i      (full)
  );

  itda_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .empty_o     (empty),
    .pop_data_o  (pop_data)
  );

  itda_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .job_i       (pop_data),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

[src/itda_checker.sv]
// Port-level assertion checker for the converter, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module itda_checker
  import itda_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input in_t  in_data_i,
  input logic out_valid_o,
  input logic out_stall_i,
  input out_t out_data_o
);

  logic char_ok;
  logic is_minus;
  logic out_held;
  logic in_held;
  logic minus_taken;
  logic digit_lead;

  assign is_minus    = (out_data_o.character == ASCII_MINUS);
  assign char_ok     = is_minus ||
                       ((out_data_o.character >= ASCII_ZERO) &&
                        (out_data_o.character <= ASCII_NINE));
  assign out_held    = out_valid_o && out_stall_i;
  assign in_held     = in_valid_i && in_stall_o;
  assign minus_taken = out_valid_o && !out_stall_i && is_minus;
  assign digit_lead  = !out_valid_o || !((out_data_o.character == ASCII_ZERO) || is_minus);

  `ITDA_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_held, out_valid_o && $stable(out_data_o))
  `ITDA_ASSERT(a_char_legal, clk_i, rst_ni, !out_valid_o || char_ok)
  `ITDA_ASSERT(a_minus_not_last, clk_i, rst_ni, !(out_valid_o && is_minus && out_data_o.last))
  `ITDA_ASSERT_NEXT(a_minus_then_digit, clk_i, rst_ni, minus_taken, digit_lead)
  `ITDA_ASSERT_NEXT(a_in_hold, clk_i, rst_ni, in_held, in_valid_i && $stable(in_data_i))

endmodule

bind integer_to_decimal_ascii itda_checker u_itda_checker (.*);

[dv/integer_to_decimal_ascii_tb.sv]
// Testbench for the integer to decimal ASCII converter, with directed and random numbers.
`timescale 1ns / 1ps

module integer_to_decimal_ascii_tb
  import itda_pkg::*;
();

  localparam logic [VALUE_W-1:0] VALUE_MASK = {VALUE_W{1'b1}} >> (VALUE_W - WIDTH);
  localparam logic [VALUE_W-1:0] MOST_NEG   = {{(VALUE_W - 1){1'b0}}, 1'b1} << (WIDTH - 1);

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  in_t  in_data_i;
  logic out_valid_o;
  logic out_stall_i;
  out_t out_data_o;

  out_t pending_chars[$];
  int   numbers_sent;
  int   negatives_sent;
  int   chars_seen;
  int   mismatches;
  bit   idling_on;

  integer_to_decimal_ascii u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  initial begin
    #20_000_000;
    $display("FAILURE");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idling_on || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic void format_decimal(input in_t item);
    logic [VALUE_W-1:0] mag;
    logic               neg;
    logic [3:0]         digits[20];
    int                 nd;
    out_t               ch;
    mag = item.value & VALUE_MASK;
    neg = (item.mode == MODE_SIGNED) && mag[WIDTH-1];
    if (neg) mag = (~mag + 1'b1) & VALUE_MASK;
    nd = 0;
    do begin
      digits[nd] = 4'(mag % 10);
      nd++;
      mag = mag / 10;
    end while (mag != 0);
    if (neg) begin
      ch.character = ASCII_MINUS;
      ch.last = 1'b0;
      pending_chars.push_back(ch);
    end
    for (int k = nd - 1; k >= 0; k--) begin
      ch.character = ASCII_ZERO + {4'd0, digits[k]};
      ch.last = (k == 0);
      pending_chars.push_back(ch);
    end
  endfunction

  task automatic send_number(input logic [VALUE_W-1:0] v, input logic m);
    int   gap;
    bit   taken;
    in_t  item;
    item.value = v;
    item.mode = m;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= item;
    do begin
      @(negedge clk_i);
      taken = !in_stall_o;
      @(posedge clk_i);
    end while (!taken);
    format_decimal(item);
    numbers_sent++;
    if (m == MODE_SIGNED && (v & MOST_NEG) != 0) negatives_sent++;
  endtask

  function automatic logic [VALUE_W-1:0] power_of_ten(input int k);
    logic [VALUE_W-1:0] p;
    p = 1;
    repeat (k) p = p * 10;
    return p;
  endfunction

  function automatic logic [VALUE_W-1:0] random_operand();
    logic [VALUE_W-1:0] full;
    int                 bits;
    full = {$urandom, $urandom};
    bits = $urandom_range(1, WIDTH);
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return full;
      4, 5, 6:    return full & (VALUE_MASK >> (WIDTH - bits));
      7:          return ~(full & (VALUE_MASK >> (WIDTH - bits)));
      8:          return power_of_ten($urandom_range(0, 19)) + $urandom_range(0, 2) - 1;
      default: begin
        if ($urandom_range(0, 1)) return MOST_NEG + $urandom_range(0, 3) - 1;
        return VALUE_MASK - $urandom_range(0, 3);
      end
    endcase
  endfunction

  always @(negedge clk_i) begin
    out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      chars_seen++;
      if (pending_chars.size() == 0) begin
        $error("unexpected character %h", out_data_o.character);
        mismatches++;
      end else begin
        want = pending_chars.pop_front();
        if (out_data_o.character !== want.character) begin
          $error("character: expected %h, got %h", want.character, out_data_o.character);
          mismatches++;
        end
        if (out_data_o.last !== want.last) begin
          $error("last: expected %b, got %b", want.last, out_data_o.last);
          mismatches++;
        end
      end
    end
  end

  initial begin
    int len;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      len = pick_gap();
      if (len > 0) begin
        out_stall_i <= 1'b1;
        repeat (len) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      repeat ($urandom_range(0, 7)) @(posedge clk_i);
    end
  end

  task automatic test_directed();
    idling_on = 1'b1;
    send_number(64'd0, MODE_SIGNED);
    send_number(64'd0, MODE_UNSIGNED);
    send_number(64'd1, MODE_SIGNED);
    send_number(VALUE_MASK, MODE_SIGNED);
    send_number(VALUE_MASK, MODE_UNSIGNED);
    send_number(MOST_NEG, MODE_SIGNED);
    send_number(MOST_NEG, MODE_UNSIGNED);
    send_number(MOST_NEG - 1, MODE_SIGNED);
    send_number(MOST_NEG + 1, MODE_SIGNED);
    send_number(64'd9, MODE_UNSIGNED);
    send_number(64'd10, MODE_SIGNED);
    send_number(64'd99, MODE_UNSIGNED);
    send_number(64'd100, MODE_SIGNED);
    send_number(-64'sd10, MODE_SIGNED);
    send_number(power_of_ten(19), MODE_UNSIGNED);
    send_number(power_of_ten(19) - 1, MODE_UNSIGNED);
    send_number(power_of_ten(18), MODE_SIGNED);
    send_number(64'hAAAA_AAAA_AAAA_AAAA, MODE_UNSIGNED);
    send_number(64'h5555_5555_5555_5555, MODE_SIGNED);
  endtask

  task automatic test_random_with_gaps(input int count);
    idling_on = 1'b1;
    repeat (count) send_number(random_operand(), 1'($urandom_range(0, 1)));
  endtask

  task automatic test_back_to_back(input int count);
    idling_on = 1'b0;
    repeat (count) send_number(random_operand(), 1'($urandom_range(0, 1)));
  endtask

  initial begin
    rst_ni <= 1'b0;
    in_valid_i <= 1'b0;
    in_data_i <= '0;
    out_stall_i <= 1'b0;
    numbers_sent = 0;
    negatives_sent = 0;
    chars_seen = 0;
    mismatches = 0;
    idling_on = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random_with_gaps(130);
    test_back_to_back(60);
    test_random_with_gaps(70);

    in_valid_i <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);

    $display("Converted %0d numbers (%0d negative signed) into %0d characters,",
             numbers_sent, negatives_sent, chars_seen);
    $display("covering zero, both extremes, powers of ten and random magnitudes.");
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+src
src/itda_pkg.sv
src/itda_queue.sv
src/itda_front.sv
src/itda_back.sv
src/integer_to_decimal_ascii.sv
src/itda_checker.sv
dv/integer_to_decimal_ascii_tb.sv
